// ----- hw/rtl/websocket_frame_deframer_top_defines.svh -----
// Assertion helpers for the deframer top-level RTL.
// Each macro expands to one labeled concurrent assertion, clocked on clk and
// disabled while rst is high.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/wsd_pkg.sv -----
package wsd_pkg;

  // Default size of the receive buffer in bytes.
  localparam int BUFFER_DEPTH_DEFAULT = 128;

  // Frame layout and header codes.
  localparam logic [7:0] HDR_BYTES    = 8'd6;
  localparam logic [7:0] FIRST_PAYLOAD = 8'd7;
  localparam logic [6:0] LEN_TOO_LONG = 7'd125;
  localparam logic [3:0] OPC_TEXT     = 4'h1;
  localparam logic [3:0] OPC_CLOSE    = 4'h8;

  // Request selector on the input side.
  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_OPEN    = 2'd1,
    FUNC_TIMEOUT = 2'd2
  } func_t;

  // Result kind on the output side.
  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_CLOSE    = 3'd1,
    KIND_TOO_LONG = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_ABORT    = 3'd4,
    KIND_EMPTY    = 3'd5
  } kind_t;

  // Deframer state held between requests.
  typedef struct packed {
    logic [7:0]  position;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [31:0] mask_key;
    logic        conn_open;
    logic        released;
  } wsd_state_t;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic [3:0] opcode;
    logic       last;
  } wsd_result_t;

endpackage

// ----- hw/rtl/websocket_frame_deframer_top.sv -----
// A request waits in the input register; the combinational core decodes it and
// its result, if any, is loaded into the result register on the master side.
// Throughput: one request per cycle while m_tready holds; the input register and
// the result register each hold one item, so the core step runs whenever the
// result register is free. Reset (rst, synchronous, active high) clears both
// valid flags and all frame state; the connection starts closed.
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top import wsd_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // payload[7:0], opcode[11:8], zero fill[15:12]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast    // last
);

  logic        in_valid;
  func_t       in_func;
  logic [7:0]  in_byte;
  logic        out_ready;
  logic        advance;
  wsd_state_t  state;
  wsd_state_t  state_next;
  logic        res_valid;
  wsd_result_t res;

  // The held request is processed whenever the result register can take it.
  assign advance  = in_valid && out_ready;
  assign s_tready = !in_valid || out_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= func_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  // Frame state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  wsd_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .func       (in_func),
    .data_byte  (in_byte),
    .state      (state),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  wsd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .ready    (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Checks on the internal control.
  `WSD_ASSERT_SAME(a_hold_blocks_input, in_valid && !advance, !s_tready, "input overrun")
  `WSD_ASSERT_SAME(a_position_bound, 1'b1, state.position < 8'(BUFFER_DEPTH), "position at depth")
  `WSD_ASSERT_NEXT(a_close_shuts, advance && res_valid && (res.kind == KIND_CLOSE), !state.conn_open, "close left connection open")
  `WSD_ASSERT_SAME(a_non_payload_clean, m_tvalid && (m_tuser != KIND_PAYLOAD), (m_tdata[7:0] == 8'd0) && !m_tlast, "non-payload result carries data")

endmodule

// ----- hw/rtl/wsd_core.sv -----
module wsd_core import wsd_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  func_t       func,
  input  logic [7:0]  data_byte,
  input  wsd_state_t  state,
  output wsd_state_t  state_next,
  output logic        res_valid,
  output wsd_result_t res
);

  localparam logic [7:0] DEPTH = 8'(BUFFER_DEPTH);

  logic [7:0]  count;
  logic [7:0]  h0;
  logic [7:0]  h1;
  logic [31:0] mask;
  logic [3:0]  opc;
  logic [6:0]  len;
  logic        frame_ok;
  logic        overflow;
  logic [7:0]  pay_idx;
  logic [7:0]  mask_byte;
  logic [7:0]  plain;

  // Header capture: the first six bytes of a frame fill the header registers.
  always_comb begin
    h0   = state.hdr0;
    h1   = state.hdr1;
    mask = state.mask_key;
    case (state.position)
      8'd0: h0 = data_byte;
      8'd1: h1 = data_byte;
      8'd2: mask[31:24] = data_byte;
      8'd3: mask[23:16] = data_byte;
      8'd4: mask[15:8]  = data_byte;
      8'd5: mask[7:0]   = data_byte;
      default: ;
    endcase
  end

  // Frame decode and unmasking of the current byte.
  assign count    = state.position + 8'd1;
  assign opc      = h0[3:0];
  assign len      = h1[6:0];
  assign frame_ok = state.conn_open && (count > HDR_BYTES) &&
                    !(!h0[7] && (opc != OPC_TEXT) && (opc != OPC_CLOSE));
  assign overflow = count >= DEPTH;
  assign pay_idx  = count - FIRST_PAYLOAD;

  always_comb begin
    mask_byte = 8'd0;
    if (h1[7]) begin
      case (pay_idx[1:0])
        2'd0: mask_byte = mask[31:24];
        2'd1: mask_byte = mask[23:16];
        2'd2: mask_byte = mask[15:8];
        default: mask_byte = mask[7:0];
      endcase
    end
  end

  assign plain = data_byte ^ mask_byte;

  // Next state and result for one request.
  always_comb begin
    state_next     = state;
    res_valid      = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.payload    = 8'd0;
    res.opcode     = state.hdr0[3:0];
    res.last       = 1'b0;
    case (func)
      FUNC_BYTE: begin
        res.opcode          = opc;
        state_next.hdr0     = h0;
        state_next.hdr1     = h1;
        state_next.mask_key = mask;
        state_next.position = count;
        if (frame_ok && (len >= LEN_TOO_LONG)) begin
          state_next.position = 8'd0;
          state_next.released = 1'b0;
          res_valid           = 1'b1;
          res.kind            = KIND_TOO_LONG;
        end else if (frame_ok && (opc == OPC_CLOSE) &&
                     (count >= ({1'b0, len} + HDR_BYTES))) begin
          state_next.position  = 8'd0;
          state_next.released  = 1'b0;
          state_next.conn_open = 1'b0;
          res_valid            = 1'b1;
          res.kind             = KIND_CLOSE;
        end else if (frame_ok && (opc != OPC_CLOSE) && (len == 7'd0)) begin
          state_next.position = 8'd0;
          state_next.released = 1'b0;
          res_valid           = 1'b1;
          res.kind            = KIND_EMPTY;
        end else if (frame_ok && (opc != OPC_CLOSE) && (pay_idx < {1'b0, len})) begin
          res_valid = 1'b1;
          if ((pay_idx + 8'd1) == {1'b0, len}) begin
            // Final payload byte ends the frame.
            state_next.position = 8'd0;
            state_next.released = 1'b0;
            res.payload         = plain;
            res.last            = 1'b1;
          end else if (overflow) begin
            state_next.position = 8'd0;
            state_next.released = 1'b0;
            res.kind            = KIND_OVERFLOW;
          end else begin
            state_next.released = 1'b1;
            res.payload         = plain;
          end
        end else if (overflow) begin
          state_next.position = 8'd0;
          state_next.released = 1'b0;
          res_valid           = 1'b1;
          res.kind            = KIND_OVERFLOW;
        end
      end
      FUNC_OPEN: begin
        state_next.conn_open = 1'b1;
        state_next.position  = 8'd0;
        state_next.released  = 1'b0;
      end
      FUNC_TIMEOUT: begin
        state_next.position = 8'd0;
        state_next.released = 1'b0;
        res_valid           = state.released;
        res.kind            = KIND_ABORT;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/wsd_out_stage.sv -----
module wsd_out_stage import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  wsd_result_t res,
  output logic        ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // payload[7:0], opcode[11:8], zero fill[15:12]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast    // last
);

  logic        valid;
  wsd_result_t held;

  // The register can take a new result when empty or being drained.
  assign ready = !valid || m_tready;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  // Result payload, loaded only when a new result is written.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = {4'd0, held.opcode, held.payload};
  assign m_tuser  = held.kind;
  assign m_tlast  = held.last;

endmodule

// ----- dv/websocket_frame_deframer_top_test.sv -----
module websocket_frame_deframer_top_test;
  import wsd_pkg::*;

  localparam int DEPTH = BUFFER_DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 2000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_OFF_CYCLES = 300;

  // Selector value that the block has to ignore.
  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  // Opcodes that are rejected when fin is clear.
  localparam logic [3:0] OPC_CONT = 4'h0;
  localparam logic [3:0] OPC_BINARY = 4'h2;

  localparam wsd_result_t NO_RESULT = '0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data;
    bit          typed;
    bit          has;
    wsd_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  websocket_frame_deframer_top #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Deframer state as the testbench sees it; starts in the reset state.
  logic [7:0]  frame_pos = '0;
  logic [7:0]  hdr0_q = '0;
  logic [7:0]  hdr1_q = '0;
  logic [31:0] key_q = '0;
  bit          conn_open = 1'b0;
  bit          released = 1'b0;

  wsd_result_t pending_results[$];
  wsd_result_t head_result;
  int          error_count = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          kind_seen[8];
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  bit          rx_hold_req = 1'b0;
  int          rx_hold_left = 0;
  int          rx_mode = 0;
  int unsigned rx_tick = 0;

  // Directed requests; rows with typed set carry their expected result.
  dir_row_t dir_rows [0:32] = '{
    '{FUNC_TIMEOUT, 8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_IGNORED, 8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_OPEN,    8'h00, 1'b1, 1'b0, NO_RESULT},
    // Masked text frame of three bytes, cut short by a timeout.
    '{FUNC_BYTE,    8'h81, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h83, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hA5, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h5A, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b0, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{FUNC_TIMEOUT, 8'hFF, 1'b1, 1'b1, '{KIND_ABORT, 8'h00, OPC_TEXT, 1'b0}},
    // Empty text frame.
    '{FUNC_BYTE,    8'h81, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hAB, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, OPC_TEXT, 1'b0}},
    // Close frame with the largest length is reported as too long.
    '{FUNC_BYTE,    8'h88, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h7F, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h12, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h34, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h56, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h78, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h9A, 1'b1, 1'b1, '{KIND_TOO_LONG, 8'h00, OPC_CLOSE, 1'b0}},
    // Masked close frame of length zero closes the connection at byte 7.
    '{FUNC_BYTE,    8'h88, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h80, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hDE, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hAD, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hBE, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'hEF, 1'b1, 1'b0, NO_RESULT},
    '{FUNC_BYTE,    8'h00, 1'b1, 1'b1, '{KIND_CLOSE, 8'h00, OPC_CLOSE, 1'b0}}
  };

  // Advance the deframer state by one request and return its result, if any.
  function automatic bit deframe_step(input logic [1:0] f, input logic [7:0] d,
                                      output wsd_result_t r);
    int unsigned idx;
    int unsigned cnt;
    int unsigned len;
    int unsigned i;
    logic [3:0]  opc;
    logic [7:0]  key_byte;
    bit          accepted;
    r = NO_RESULT;
    if (f == FUNC_OPEN) begin
      conn_open = 1'b1;
      frame_pos = '0;
      released = 1'b0;
      return 1'b0;
    end
    if (f == FUNC_TIMEOUT) begin
      r.kind = KIND_ABORT;
      r.opcode = hdr0_q[3:0];
      accepted = released;
      frame_pos = '0;
      released = 1'b0;
      return accepted;
    end
    if (f != FUNC_BYTE) begin
      return 1'b0;
    end

    // Only the six header bytes are stored.
    idx = 32'(frame_pos);
    cnt = idx + 1;
    if (idx == 0) begin
      hdr0_q = d;
    end else if (idx == 1) begin
      hdr1_q = d;
    end else if (idx < 6) begin
      key_q[8 * (5 - idx) +: 8] = d;
    end
    frame_pos = cnt[7:0];

    opc = hdr0_q[3:0];
    len = 32'(hdr1_q[6:0]);
    accepted = hdr0_q[7] || opc == OPC_TEXT || opc == OPC_CLOSE;
    r.opcode = opc;

    if (conn_open && cnt > HDR_BYTES && accepted) begin
      if (len >= LEN_TOO_LONG) begin
        frame_pos = '0;
        released = 1'b0;
        r.kind = KIND_TOO_LONG;
        return 1'b1;
      end
      if (opc == OPC_CLOSE) begin
        if (cnt >= len + HDR_BYTES) begin
          frame_pos = '0;
          released = 1'b0;
          conn_open = 1'b0;
          r.kind = KIND_CLOSE;
          return 1'b1;
        end
      end else if (len == 0) begin
        frame_pos = '0;
        released = 1'b0;
        r.kind = KIND_EMPTY;
        return 1'b1;
      end else begin
        i = cnt - FIRST_PAYLOAD;
        if (i < len) begin
          key_byte = hdr1_q[7] ? key_q[24 - 8 * (i % 4) +: 8] : 8'h00;
          r.payload = d ^ key_byte;
          if (i + 1 == len) begin
            frame_pos = '0;
            released = 1'b0;
            r.kind = KIND_PAYLOAD;
            r.last = 1'b1;
            return 1'b1;
          end
          if (cnt >= DEPTH) begin
            frame_pos = '0;
            released = 1'b0;
            r.kind = KIND_OVERFLOW;
            r.payload = '0;
            return 1'b1;
          end
          released = 1'b1;
          r.kind = KIND_PAYLOAD;
          return 1'b1;
        end
      end
    end
    if (cnt >= DEPTH) begin
      frame_pos = '0;
      released = 1'b0;
      r.kind = KIND_OVERFLOW;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one request in bursts with random gaps and record what it should yield.
  task automatic send_item(input logic [1:0] f, input logic [7:0] d, input bit typed,
                           input bit typed_has, input wsd_result_t typed_res);
    wsd_result_t r;
    bit          has;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    has = deframe_step(f, d, r);
    if (typed) begin
      has = typed_has;
      r = typed_res;
    end
    if (has) pending_results.push_back(r);
    if (f != FUNC_IGNORED) requests_sent++;
  endtask

  task automatic offer(input logic [1:0] f, input logic [7:0] d);
    send_item(f, d, 1'b0, 1'b0, NO_RESULT);
  endtask

  // Stop offering until every expected result has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One frame with random header and content; sometimes cut short or followed by a timeout.
  task automatic send_frame();
    logic [3:0]  opc;
    logic [2:0]  rsv;
    int unsigned sel;
    int unsigned len;
    int unsigned n;
    bit          cut;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      opc = OPC_TEXT;
    end else if (sel == 5) begin
      opc = OPC_CLOSE;
    end else if (sel == 6) begin
      opc = OPC_CONT;
    end else if (sel == 7) begin
      opc = OPC_BINARY;
    end else begin
      opc = 4'($urandom_range(0, 15));
    end
    rsv = 3'($urandom_range(0, 7));

    // Mostly short payloads, a few near the buffer size and a few too long.
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      len = 0;
    end else if (sel < 15) begin
      len = $urandom_range(1, 8);
    end else if (sel < 18) begin
      len = $urandom_range(9, 124);
    end else if (sel == 18) begin
      len = $urandom_range(122, 124);
    end else begin
      len = $urandom_range(125, 127);
    end

    offer(FUNC_BYTE, {($urandom_range(0, 3) != 0), rsv, opc});
    offer(FUNC_BYTE, {($urandom_range(0, 1) == 1), len[6:0]});
    repeat (4) offer(FUNC_BYTE, 8'($urandom_range(0, 255)));
    n = (len == 0 || len >= LEN_TOO_LONG) ? 1 : len;
    cut = ($urandom_range(0, 11) == 0);
    if (cut) n = $urandom_range(0, n - 1);
    repeat (n) offer(FUNC_BYTE, 8'($urandom_range(0, 255)));
    if (cut || $urandom_range(0, 9) == 0) offer(FUNC_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: compare each accepted result, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      kind_seen[m_tuser]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d payload %02h", m_tuser, m_tdata[7:0]);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        results_checked++;
        if (head_result.kind != m_tuser) begin
          $error("kind: expected %0d, got %0d", head_result.kind, m_tuser);
          error_count++;
        end
        if (head_result.payload != m_tdata[7:0]) begin
          $error("payload: expected %02h, got %02h", head_result.payload, m_tdata[7:0]);
          error_count++;
        end
        if (head_result.opcode != m_tdata[11:8]) begin
          $error("opcode: expected %0d, got %0d", head_result.opcode, m_tdata[11:8]);
          error_count++;
        end
        if (head_result.last != m_tlast) begin
          $error("last: expected %0d, got %0d", head_result.last, m_tlast);
          error_count++;
        end
      end
    end

    // The stall pattern is redrawn periodically from rx_tick; a hold-off request overrides it.
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= (rx_tick[1:0] != 2'd3);
        2: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Request side.
  initial begin
    int frame_no;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].func, dir_rows[k].data, dir_rows[k].typed, dir_rows[k].has,
                dir_rows[k].res);
    end
    drain();

    // Mostly well-formed frames; the rest is stray requests and closed-connection floods.
    frame_no = 0;
    while (requests_sent < RANDOM_REQUESTS + $size(dir_rows)) begin
      frame_no++;
      if (!conn_open) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat (DEPTH + 2) offer(FUNC_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) != 0) offer(FUNC_OPEN, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 19) == 0) begin
        offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        send_frame();
      end
      if (frame_no == 25 || frame_no == 120) rx_hold_req = 1'b1;
      if (frame_no % 40 == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and checked %0d results.", requests_sent, results_checked);
    $display("Results by kind (payload/close/too long/overflow/abort/empty): %0d/%0d/%0d/%0d/%0d/%0d",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_CLOSE], kind_seen[KIND_TOO_LONG],
             kind_seen[KIND_OVERFLOW], kind_seen[KIND_ABORT], kind_seen[KIND_EMPTY]);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_core.sv
hw/rtl/wsd_out_stage.sv
hw/rtl/websocket_frame_deframer_top.sv
dv/websocket_frame_deframer_top_test.sv
